/* hdl/binary_trie_max_xor_with_limit_defines.svh */
// Assertion macros for the checker file of the trie block.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef BINARY_TRIE_MAX_XOR_WITH_LIMIT_DEFINES_SVH
`define BINARY_TRIE_MAX_XOR_WITH_LIMIT_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define BTMX_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define BTMX_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/btmx_pkg.sv */
// Shared types and constants of the maximum-XOR trie block.
// No dependencies; imported by the RAM wrapper users, controller, top level and checker.
package btmx_pkg;

   // Trie geometry
   localparam int KEY_BITS   = 32;
   localparam int POOL_NODES = 65536;

   // Derived widths
   localparam int LINK_W  = $clog2(POOL_NODES);
   localparam int USED_W  = $clog2(POOL_NODES + 1);
   localparam int NODE_W  = 2 * LINK_W + KEY_BITS;
   localparam int LVL_W   = $clog2(KEY_BITS + 1);
   localparam int BIT_W   = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
   localparam int FIELD_W = 32;
   localparam int OP_W    = 2;

   // Stream word widths
   localparam int REQ_DATA_W = ((2 * FIELD_W + 7) / 8) * 8;
   localparam int REQ_USER_W = OP_W;
   localparam int RSP_DATA_W = ((FIELD_W + 7) / 8) * 8;
   localparam int RSP_USER_W = 2;

   // Node pool counts
   localparam logic [USED_W-1:0] USED_ONE       = USED_W'(1);
   localparam logic [USED_W-1:0] POOL_COUNT     = USED_W'(POOL_NODES);
   localparam logic [USED_W-1:0] SCAN_THRESHOLD = USED_W'(POOL_NODES - KEY_BITS);

   // Operation codes
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

   typedef logic [LINK_W-1:0]   link_type;
   typedef logic [KEY_BITS-1:0] key_type;

   // One trie node: two child links (zero = absent) and the subtree minimum
   typedef struct packed {
      link_type link1;
      link_type link0;
      key_type  min_key;
   } node_type;

   // Node pool access from the controller
   typedef struct packed {
      link_type rd_addr_a;
      link_type rd_addr_b;
      logic     wr_en;
      link_type wr_addr;
      node_type wr_data;
   } mem_req_type;

   // Finished result from the controller
   typedef struct packed {
      logic               valid;
      logic [FIELD_W-1:0] max_xor;
      logic               found;
      logic               pool_full;
   } result_type;

endpackage

/* hdl/btmx_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies; used for every copy of the node pool.
module btmx_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] storage_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         storage_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= storage_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/btmx_ctrl.sv */
// Sequencer of the trie: clear, insert (with optional capacity scan) and query walks.
// Depends on btmx_pkg; drives two node pool copies with one shared write port.
module btmx_ctrl
   import btmx_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [OP_W-1:0]    req_op,
   input  logic [FIELD_W-1:0] req_key,
   input  logic [FIELD_W-1:0] req_limit,
   input  node_type           rd_data_a,
   input  node_type           rd_data_b,
   output mem_req_type        mem_req,
   input  logic               res_free,
   output result_type         result
);

   typedef enum logic [6:0] {
      ST_INIT   = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_Q_ROOT = 7'b0000100,
      ST_Q_WALK = 7'b0001000,
      ST_I_SCAN = 7'b0010000,
      ST_I_WALK = 7'b0100000,
      ST_RESULT = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [LVL_W-1:0]   lvl_ff, lvl_in;
   key_type            key_ff, key_in;
   logic [FIELD_W-1:0] limit_ff, limit_in;
   logic [USED_W-1:0]  used_ff, used_in;
   link_type           cur_ff, cur_in;
   logic               alloc_ff, alloc_in;
   link_type           qlink0_ff, qlink0_in;
   link_type           qlink1_ff, qlink1_in;
   key_type            xor_ff, xor_in;
   logic               found_ff, found_in;
   logic               full_ff, full_in;

   logic [BIT_W-1:0]  bit_idx;
   logic              key_bit;
   logic [USED_W-1:0] free_nodes;

   // Insert walk signals
   node_type cur_node;
   node_type wr_node;
   logic     is_root;
   logic     take_key;
   link_type next_link;
   logic     need_alloc;
   link_type child;

   // Capacity scan signals
   link_type scan_link;
   logic     scan_full;

   // Query walk signals
   link_type alt_idx;
   node_type alt_node;
   node_type keep_node;
   logic     take_alt;
   node_type chosen;
   logic     root_reject;

   // Bit of the key that selects the branch at this level
   assign bit_idx    = BIT_W'(lvl_ff - LVL_W'(1));
   assign key_bit    = key_ff[bit_idx];
   assign free_nodes = POOL_COUNT - used_ff;

   // Insert: update the node on the path, link or allocate its child
   always_comb begin
      cur_node   = alloc_ff ? node_type'{link1: '0, link0: '0, min_key: key_ff} : rd_data_a;
      is_root    = (lvl_ff == LVL_W'(KEY_BITS));
      take_key   = is_root ? ((used_ff == USED_ONE) || (key_ff < cur_node.min_key))
                           : (key_ff < cur_node.min_key);
      next_link  = key_bit ? cur_node.link1 : cur_node.link0;
      need_alloc = (next_link == '0);
      child      = need_alloc ? used_ff[LINK_W-1:0] : next_link;
      wr_node    = cur_node;
      if (take_key) begin
         wr_node.min_key = key_ff;
      end
      if (lvl_ff != '0) begin
         if (key_bit) begin
            wr_node.link1 = child;
         end else begin
            wr_node.link0 = child;
         end
      end
   end

   // Capacity scan: nodes still missing below this level versus free nodes
   assign scan_link = key_bit ? rd_data_a.link1 : rd_data_a.link0;
   assign scan_full = (scan_link == '0) && (USED_W'(lvl_ff) > free_nodes);

   // Query: prefer the child opposite to the value bit if it holds a key within limit
   assign alt_idx     = key_bit ? qlink0_ff : qlink1_ff;
   assign alt_node    = key_bit ? rd_data_a : rd_data_b;
   assign keep_node   = key_bit ? rd_data_b : rd_data_a;
   assign take_alt    = (alt_idx != '0) && (FIELD_W'(alt_node.min_key) <= limit_ff);
   assign chosen      = take_alt ? alt_node : keep_node;
   assign root_reject = (used_ff == USED_ONE) || (FIELD_W'(rd_data_a.min_key) > limit_ff);

   // Next-state and datapath control
   always_comb begin
      state_in  = state_ff;
      lvl_in    = lvl_ff;
      key_in    = key_ff;
      limit_in  = limit_ff;
      used_in   = used_ff;
      cur_in    = cur_ff;
      alloc_in  = alloc_ff;
      qlink0_in = qlink0_ff;
      qlink1_in = qlink1_ff;
      xor_in    = xor_ff;
      found_in  = found_ff;
      full_in   = full_ff;
      mem_req   = '0;
      req_ready = 1'b0;
      result    = '0;

      unique case (state_ff)
         ST_INIT: begin
            // Empty the root once after reset
            mem_req.wr_en = 1'b1;
            used_in       = USED_ONE;
            state_in      = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               key_in   = req_key[KEY_BITS-1:0];
               limit_in = req_limit;
               lvl_in   = LVL_W'(KEY_BITS);
               cur_in   = '0;
               alloc_in = 1'b0;
               xor_in   = '0;
               found_in = 1'b0;
               full_in  = 1'b0;
               case (req_op)
                  OP_CLEAR: begin
                     mem_req.wr_en = 1'b1;
                     used_in       = USED_ONE;
                     state_in      = ST_RESULT;
                  end
                  OP_INSERT: begin
                     state_in = (used_ff > SCAN_THRESHOLD) ? ST_I_SCAN : ST_I_WALK;
                  end
                  OP_QUERY: begin
                     state_in = ST_Q_ROOT;
                  end
                  default: begin
                     state_in = ST_RESULT;
                  end
               endcase
            end
         end
         ST_I_SCAN: begin
            // Count missing nodes along the path before touching anything
            if ((scan_link == '0) || (lvl_ff == LVL_W'(1))) begin
               if (scan_full) begin
                  full_in  = 1'b1;
                  state_in = ST_RESULT;
               end else begin
                  lvl_in   = LVL_W'(KEY_BITS);
                  state_in = ST_I_WALK;
               end
            end else begin
               mem_req.rd_addr_a = scan_link;
               lvl_in            = lvl_ff - LVL_W'(1);
            end
         end
         ST_I_WALK: begin
            // Write back the current node, then advance to its child
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cur_ff;
            mem_req.wr_data = wr_node;
            if (lvl_ff == '0) begin
               state_in = ST_RESULT;
            end else begin
               mem_req.rd_addr_a = child;
               cur_in            = child;
               lvl_in            = lvl_ff - LVL_W'(1);
               if (need_alloc) begin
                  used_in  = used_ff + USED_W'(1);
                  alloc_in = 1'b1;
               end
            end
         end
         ST_Q_ROOT: begin
            if (root_reject) begin
               state_in = ST_RESULT;
            end else begin
               mem_req.rd_addr_a = rd_data_a.link0;
               mem_req.rd_addr_b = rd_data_a.link1;
               qlink0_in         = rd_data_a.link0;
               qlink1_in         = rd_data_a.link1;
               state_in          = ST_Q_WALK;
            end
         end
         ST_Q_WALK: begin
            // Decide one result bit, fetch both children of the chosen node
            xor_in[bit_idx] = take_alt;
            if (lvl_ff == LVL_W'(1)) begin
               found_in = 1'b1;
               state_in = ST_RESULT;
            end else begin
               mem_req.rd_addr_a = chosen.link0;
               mem_req.rd_addr_b = chosen.link1;
               qlink0_in         = chosen.link0;
               qlink1_in         = chosen.link1;
               lvl_in            = lvl_ff - LVL_W'(1);
            end
         end
         ST_RESULT: begin
            // Hold until the output register can take the word
            result.valid     = 1'b1;
            result.max_xor   = FIELD_W'(xor_ff);
            result.found     = found_ff;
            result.pool_full = full_ff;
            if (res_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         used_ff  <= USED_ONE;
         lvl_ff   <= '0;
         alloc_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         lvl_ff   <= lvl_in;
         alloc_ff <= alloc_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      limit_ff  <= limit_in;
      cur_ff    <= cur_in;
      qlink0_ff <= qlink0_in;
      qlink1_ff <= qlink1_in;
      xor_ff    <= xor_in;
      found_ff  <= found_in;
      full_ff   <= full_in;
   end

endmodule

/* hdl/binary_trie_max_xor_with_limit.sv */
// Top level of the maximum-XOR trie: stream ports, node pool copies and output register.
// Depends on btmx_pkg, btmx_ram and btmx_ctrl.
//
//   channel | direction | words carried
//   --------+-----------+---------------------------------------------------
//   req_*   | in        | tdata: key_value[31:0], limit[63:32]; tuser: op
//   rsp_*   | out       | tdata: max_xor; tuser: found[0], pool_full[1]
//
// Query: one trie level per node pool read; both children are fetched together
//   from two copies of the pool.
// Insert: one read-modify-write per level; with fewer than KEY_BITS free nodes a
//   read-only capacity scan runs first.
// Clear and unused op codes go straight from idle to the result. Reset empties the root once.
// A new word is accepted while the previous result waits in the output register.
module binary_trie_max_xor_with_limit
   import btmx_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // key_value, limit
   input  logic [REQ_USER_W-1:0] req_tuser,   // op
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // max_xor
   output logic [RSP_USER_W-1:0] rsp_tuser    // found, pool_full
);

   mem_req_type mem_req;
   result_type  result;
   node_type    rd_data_a;
   node_type    rd_data_b;
   logic        res_free;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   btmx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (req_tuser[OP_W-1:0]),
      .req_key   (req_tdata[FIELD_W-1:0]),
      .req_limit (req_tdata[2*FIELD_W-1:FIELD_W]),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .mem_req   (mem_req),
      .res_free  (res_free),
      .result    (result)
   );

   // Two copies of the node pool written together, one read port each
   btmx_ram #(
      .WIDTH (NODE_W),
      .DEPTH (POOL_NODES)
   ) u_pool_a (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_addr (mem_req.rd_addr_a),
      .rd_data (rd_data_a)
   );

   btmx_ram #(
      .WIDTH (NODE_W),
      .DEPTH (POOL_NODES)
   ) u_pool_b (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_addr (mem_req.rd_addr_b),
      .rd_data (rd_data_b)
   );

   // Output register: load a finished result once the previous word is taken
   assign res_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (res_free) begin
         rsp_valid_in = result.valid;
         if (result.valid) begin
            rsp_data_in = RSP_DATA_W'(result.max_xor);
            rsp_user_in = {result.pool_full, result.found};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

/* hdl/btmx_checker.sv */
// Port-level checker of the maximum-XOR trie, bound to the top level.
// Depends on btmx_pkg and the assertion macros header.
`include "binary_trie_max_xor_with_limit_defines.svh"

module btmx_checker
   import btmx_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,   // max_xor
   input logic [RSP_USER_W-1:0] rsp_tuser    // found, pool_full
);

   // Hold a stalled result word
   `BTMX_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result word changed while stalled")

   // A query hit and a dropped insert never share one result
   `BTMX_ASSERT_SAME(a_flags_exclusive, clock, reset, rsp_tvalid, !(rsp_tuser[0] && rsp_tuser[1]), "found and pool_full both set")

   // Without a hit the xor field reads zero
   `BTMX_ASSERT_SAME(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata == '0, "max_xor nonzero without found")

   // A new result appears only while the input side is busy
   `BTMX_ASSERT_SAME(a_rsp_after_busy, clock, reset, $rose(rsp_tvalid), !$past(req_tready), "result appeared while input was ready")

endmodule

bind binary_trie_max_xor_with_limit btmx_checker u_checker (.*);
